FILE: sv/hfr_pkg.sv
// shared types and constants for the handoff frame reassembler
// no dependencies
`timescale 1ns / 1ps

package hfr_pkg;

    localparam logic [7:0] PAGE_CODE     = 8'h12;
    localparam logic [3:0] COUNT_M1      = 4'd1;
    localparam logic [1:0] FULL_MASK     = 2'b11;
    localparam int         PHASE_W       = 13;
    localparam logic [PHASE_W-1:0] PHASE_RST = 13'h1FFF;

    localparam logic [2:0] ST_PARTIAL    = 3'd0;
    localparam logic [2:0] ST_COMPLETE   = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER = 3'd2;
    localparam logic [2:0] ST_PROTOCOL   = 3'd3;
    localparam logic [2:0] ST_INVALID    = 3'd4;

    localparam logic [2:0] ADDR_PHASE    = 3'd0;

    typedef struct packed {
        logic        hdr_ok;
        logic        idx;
        logic [7:0]  counter;
        logic [31:0] area;
        logic [7:0]  tag;
    } t_frame;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         counter;
        logic [15:0]        node_number;
        logic [6:0]         node_class;
        logic [7:0]         transmission_type;
        logic [15:0]        channel_period;
        logic [PHASE_W-1:0] slot_phase;
        logic [2:0]         clock_code;
    } t_result;

endpackage

FILE: sv/hfr_front.sv
// front part: header classification and a two-entry frame queue
// depends on hfr_pkg
`timescale 1ns / 1ps

module hfr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic [7:0]     i_page_id,
    input  logic [7:0]     i_handoff_count,
    input  logic [7:0]     i_index_byte,
    input  logic [31:0]    i_field_area,
    input  logic [7:0]     i_tag_byte,
    output logic           o_valid,
    output hfr_pkg::t_frame o_frame,
    input  logic           i_take
);

    hfr_pkg::t_frame r_q [2];
    hfr_pkg::t_frame s_in;
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt, n_cnt;
    logic            s_wr, s_rd;

    always_comb begin
        s_in.hdr_ok  = (i_page_id == hfr_pkg::PAGE_CODE)
                    && (i_index_byte[3:0] == hfr_pkg::COUNT_M1)
                    && (i_index_byte[7:5] == 3'd0);
        s_in.idx     = i_index_byte[4];
        s_in.counter = i_handoff_count;
        s_in.area    = i_field_area;
        s_in.tag     = i_tag_byte;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_frame = r_q[r_rp];
    assign s_wr    = i_push && !o_full;
    assign s_rd    = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (s_wr && !s_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (s_rd && !s_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (s_wr) begin
                r_wp <= ~r_wp;
            end
            if (s_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_q[r_wp] <= s_in;
        end
    end

endmodule

FILE: sv/hfr_back.sv
// back part: set tracking, frame store, pair decode and checks
// depends on hfr_pkg
`timescale 1ns / 1ps

module hfr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [hfr_pkg::PHASE_W-1:0]     i_phase_limit,
    input  logic                            i_valid,
    input  hfr_pkg::t_frame                 i_frame,
    output logic                            o_take,
    input  logic                            i_res_full,
    output logic                            o_res_push,
    output hfr_pkg::t_result                o_result
);

    logic        r_started, n_started;
    logic [7:0]  r_counter, n_counter;
    logic [1:0]  r_held, n_held;
    logic [39:0] r_store [2];
    logic [39:0] s_e0, s_e1, s_new;
    logic [1:0]  s_base;
    logic        s_newset;

    assign o_take     = i_valid && !i_res_full;
    assign o_res_push = o_take;
    assign s_new      = {i_frame.area, i_frame.tag};
    assign s_e0       = (i_frame.idx == 1'b0) ? s_new : r_store[0];
    assign s_e1       = (i_frame.idx == 1'b1) ? s_new : r_store[1];
    assign s_newset   = !r_started || (i_frame.counter != r_counter);
    assign s_base     = s_newset ? 2'b00 : r_held;

    always_comb begin
        n_started = r_started;
        n_counter = r_counter;
        n_held    = r_held;
        o_result  = '0;
        if (!i_frame.hdr_ok) begin
            o_result.status = hfr_pkg::ST_BAD_HEADER;
        end else begin
            n_started = 1'b1;
            n_counter = i_frame.counter;
            n_held    = s_base | (i_frame.idx ? 2'b10 : 2'b01);
            if (n_held != hfr_pkg::FULL_MASK) begin
                o_result.status = hfr_pkg::ST_PARTIAL;
            end else if (s_e0[8] || (s_e0[7:0] != 8'd0) || (s_e1[7:0] != 8'd0)) begin
                o_result.status = hfr_pkg::ST_PROTOCOL;
                n_held          = 2'b00;
                n_started       = 1'b0;
            end else if ((s_e1[39:24] == 16'd0) || (s_e0[23:17] == 7'd0)
                         || (s_e1[23:11] > i_phase_limit)) begin
                o_result.status = hfr_pkg::ST_INVALID;
                n_held          = 2'b00;
                n_started       = 1'b0;
            end else begin
                o_result.status            = hfr_pkg::ST_COMPLETE;
                o_result.counter           = i_frame.counter;
                o_result.node_number       = s_e0[39:24];
                o_result.node_class        = s_e0[23:17];
                o_result.transmission_type = s_e0[16:9];
                o_result.channel_period    = s_e1[39:24];
                o_result.slot_phase        = s_e1[23:11];
                o_result.clock_code        = s_e1[10:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_counter <= 8'd0;
            r_held    <= 2'b00;
        end else if (o_take) begin
            r_started <= n_started;
            r_counter <= n_counter;
            r_held    <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_frame.hdr_ok) begin
            r_store[i_frame.idx] <= s_new;
        end
    end

endmodule

FILE: sv/hfr_resq.sv
// two-entry result queue driving the result side
// depends on hfr_pkg
`timescale 1ns / 1ps

module hfr_resq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hfr_pkg::t_result i_result,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output hfr_pkg::t_result o_result
);

    hfr_pkg::t_result r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             s_wr, s_rd;

    assign o_full   = (r_cnt == 2'd2);
    assign o_empty  = (r_cnt == 2'd0);
    assign o_result = r_q[r_rp];
    assign s_wr     = i_push && !o_full;
    assign s_rd     = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (s_wr && !s_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (s_rd && !s_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (s_wr) begin
                r_wp <= ~r_wp;
            end
            if (s_rd) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_q[r_wp] <= i_result;
        end
    end

endmodule

FILE: sv/handoff_frame_reassembler_top.sv
// top level: phase limit register, front queue, back decode and result queue
// depends on hfr_pkg, hfr_front, hfr_back, hfr_resq
`timescale 1ns / 1ps

// Takes one 8-byte frame of a two-frame handoff page per transfer and gives
// one result per frame: partial, complete with decoded fields, bad header,
// protocol violation or invalid content. Each frame passes a two-entry
// input queue, a combinational decode and a two-entry result queue, so one
// frame per cycle is sustained unless the result queue fills; the frame and
// then its result are registered in the two queues. The phase limit register
// reads at byte address 0, is written at 0 to 3 and resets to 8191.
module handoff_frame_reassembler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_page_id,
    input  logic [7:0]  i_handoff_count,
    input  logic [7:0]  i_index_byte,
    input  logic [31:0] i_field_area,
    input  logic [7:0]  i_tag_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_counter,
    output logic [15:0] o_node_number,
    output logic [6:0]  o_node_class,
    output logic [7:0]  o_transmission_type,
    output logic [15:0] o_channel_period,
    output logic [12:0] o_slot_phase,
    output logic [2:0]  o_clock_code
);

    logic [hfr_pkg::PHASE_W-1:0] r_phase_limit;
    logic             s_fr_valid, s_take, s_res_full, s_res_push;
    hfr_pkg::t_frame  s_frame;
    hfr_pkg::t_result s_res_in, s_res_out;

    assign pready = 1'b1;
    assign prdata = (paddr == hfr_pkg::ADDR_PHASE)
                  ? {{(32-hfr_pkg::PHASE_W){1'b0}}, r_phase_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_limit <= hfr_pkg::PHASE_RST;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_phase_limit <= pwdata[hfr_pkg::PHASE_W-1:0];
        end
    end

    hfr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_page_id       (i_page_id),
        .i_handoff_count (i_handoff_count),
        .i_index_byte    (i_index_byte),
        .i_field_area    (i_field_area),
        .i_tag_byte      (i_tag_byte),
        .o_valid         (s_fr_valid),
        .o_frame         (s_frame),
        .i_take          (s_take)
    );

    hfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_limit (r_phase_limit),
        .i_valid       (s_fr_valid),
        .i_frame       (s_frame),
        .o_take        (s_take),
        .i_res_full    (s_res_full),
        .o_res_push    (s_res_push),
        .o_result      (s_res_in)
    );

    hfr_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_res_push),
        .i_result (s_res_in),
        .o_full   (s_res_full),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (s_res_out)
    );

    assign o_status            = s_res_out.status;
    assign o_out_counter       = s_res_out.counter;
    assign o_node_number       = s_res_out.node_number;
    assign o_node_class        = s_res_out.node_class;
    assign o_transmission_type = s_res_out.transmission_type;
    assign o_channel_period    = s_res_out.channel_period;
    assign o_slot_phase        = s_res_out.slot_phase;
    assign o_clock_code        = s_res_out.clock_code;

endmodule
